@@ rtl/lzss_tgp_pkg.sv @@
package lzss_tgp_pkg;

    localparam int GROUP_SIZE = 8;
    localparam int IDX_W      = $clog2(GROUP_SIZE);
    localparam int LEN_BIAS   = 3;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_TOKEN = 2'd1,
        REQ_FINAL = 2'd2
    } req_t;

    typedef struct packed {
        logic        lit;
        logic [7:0]  byte_val;
        logic [11:0] dist_val;
        logic [4:0]  len;
    } tok_t;

endpackage

@@ rtl/lzss_token_group_packer.sv @@
// Token item: one that does not fill a group is only stored; one that fills it is followed
// by the flag byte and 8..16 token bytes at one byte per cycle while out_ready holds.
// Checksum item: added to the sum. Finalize: partial group flush (flag byte plus 1..14
// token bytes) when tokens are held, then 4 sum bytes, one per cycle while out_ready holds.
// Output register decouples the sides; emission stalls only on out_ready.
// Reset (rst_n, async low) clears token count, flags, sum and size count.
module lzss_token_group_packer
    import lzss_tgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    input  logic        is_literal,
    input  logic [7:0]  token_byte,
    input  logic [11:0] match_distance,
    input  logic [4:0]  match_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [31:0] total_size
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLAG,
        ST_TOK,
        ST_HI,
        ST_SUM
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     last_idx_reg, last_idx_next;
    logic [GROUP_SIZE-1:0] flags_reg, flags_next;
    logic                 fin_reg, fin_next;
    logic [1:0]           k_reg, k_next;
    logic [31:0]          sum_reg, sum_next;
    logic [31:0]          size_reg, size_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 last_reg, last_next;

    logic             can_push;
    logic             push;
    logic [7:0]       pbyte;
    logic             plast;
    logic             adv;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    tok_t             wr_tok;
    tok_t             rd_tok;
    logic [4:0]       len_m3;

    assign wr_tok.lit      = is_literal;
    assign wr_tok.byte_val = token_byte;
    assign wr_tok.dist_val = match_distance;
    assign wr_tok.len      = match_length;

    lzss_tgp_tok_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg),
        .wr_data (wr_tok),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_tok)
    );

    assign can_push = !out_valid_reg || out_ready;
    assign len_m3   = rd_tok.len - 5'(LEN_BIAS);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        flags_next     = flags_reg;
        fin_next       = fin_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        push           = 1'b0;
        pbyte          = 8'd0;
        plast          = 1'b0;
        adv            = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_BYTE:
                        begin
                            sum_next = sum_reg + {24'd0, data_byte};
                        end
                        REQ_TOKEN:
                        begin
                            wr_en = 1'b1;
                            flags_next[cnt_reg] = is_literal;
                            if (cnt_reg == IDX_W'(GROUP_SIZE - 1))
                            begin
                                last_idx_next = cnt_reg;
                                cnt_next      = '0;
                                fin_next      = 1'b0;
                                state_next    = ST_FLAG;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        REQ_FINAL:
                        begin
                            fin_next = 1'b1;
                            k_next   = '0;
                            if (cnt_reg != '0)
                            begin
                                last_idx_next = cnt_reg - 1'b1;
                                cnt_next      = '0;
                                state_next    = ST_FLAG;
                            end
                            else
                            begin
                                state_next = ST_SUM;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FLAG:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    pbyte      = flags_reg;
                    flags_next = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = ST_TOK;
                end
            end
            ST_TOK:
            begin
                if (can_push)
                begin
                    push = 1'b1;
                    if (rd_tok.lit)
                    begin
                        pbyte = rd_tok.byte_val;
                        adv   = 1'b1;
                    end
                    else
                    begin
                        pbyte      = rd_tok.dist_val[7:0];
                        state_next = ST_HI;
                    end
                end
            end
            ST_HI:
            begin
                if (can_push)
                begin
                    push  = 1'b1;
                    pbyte = {rd_tok.dist_val[11:8], len_m3[3:0]};
                    adv   = 1'b1;
                end
            end
            ST_SUM:
            begin
                if (can_push)
                begin
                    push  = 1'b1;
                    pbyte = 8'(sum_reg >> {k_reg, 3'b000});
                    if (k_reg == 2'd3)
                    begin
                        plast      = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            if (idx_reg == last_idx_reg)
            begin
                if (fin_reg)
                begin
                    k_next     = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    plast      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            else
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg + 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_TOK;
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        size_next      = size_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = pbyte;
            last_next      = plast;
            size_next      = size_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            flags_reg     <= '0;
            fin_reg       <= 1'b0;
            k_reg         <= '0;
            sum_reg       <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            flags_reg     <= flags_next;
            fin_reg       <= fin_next;
            k_reg         <= k_next;
            sum_reg       <= sum_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            last_reg      <= last_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = last_reg;
    assign total_size = size_reg;

endmodule

@@ rtl/lzss_tgp_tok_store.sv @@
module lzss_tgp_tok_store
    import lzss_tgp_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  tok_t             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output tok_t             rd_data
);

    tok_t mem [GROUP_SIZE];
    tok_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
